// File: rtl/core/hrbp_pkg.sv
// ----------------------------------------------------------------------------
// hrbp_pkg: shared types and constants of the http request byte parser
// line store size, beat codes, header keys and the check handshake structs
// ----------------------------------------------------------------------------
`default_nettype none

package hrbp_pkg;

  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] TK_NONE        = 3'd0;
  localparam logic [2:0] TK_METHOD_CHAR = 3'd1;
  localparam logic [2:0] TK_PATH_CHAR   = 3'd2;
  localparam logic [2:0] TK_VER_CHAR    = 3'd3;
  localparam logic [2:0] TK_BODY_CHAR   = 3'd4;
  localparam logic [2:0] TK_METHOD_END  = 3'd5;
  localparam logic [2:0] TK_PATH_END    = 3'd6;
  localparam logic [2:0] TK_VER_END     = 3'd7;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int TYPE_KEY_LEN = 13;
  localparam int LEN_KEY_LEN  = 15;

  localparam logic [7:0] TYPE_KEY [16] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "T", "y", "p", "e", ":",
    8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] LEN_KEY [16] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":",
    8'h00
  };

  localparam logic [7:0] JSON_WORD [16] = '{
    "a", "p", "p", "l", "i", "c", "a", "t", "i", "o", "n", "/", "j", "s", "o", "n"
  };

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } line_wr_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } chk_req_t;

  typedef struct packed {
    logic        done;
    logic        type_bad;
    logic        len_hit;
    logic [15:0] len_val;
  } chk_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/http_request_byte_parser.sv
// ----------------------------------------------------------------------------
// http_request_byte_parser: byte serial http request parser
// tags request line characters, checks headers and passes the body through
//
// input beats: tuser is the mode (byte, tick, restart), tdata the byte.
// every input beat gives exactly one output beat: a token kind in tuser,
// and char, done, valid flag and content length in tdata.
// for most beats the result is registered the cycle after acceptance and
// the next beat can be taken in that same cycle.
// a CR that ends a non-empty header line starts a walk of the line store,
// one byte per cycle through the check unit; tready stays low until the
// check unit returns its result.
// a stalled output holds its beat; tready drops until it is taken.
// reset clears the parser to the start of a request and sets the idle
// timeout to 1000 ticks; a restart beat does the same but keeps the timeout.
// cfg_we writes the idle timeout; use it only while the parser is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_byte_parser import hrbp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [1:0]  s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // char_out, done_res, request_valid,
                                           // content_length, zero pad
  output logic [2:0]       m_axis_tuser    // token_kind
);

  typedef enum logic [2:0] {
    PH_METHOD, PH_PATH, PH_VERSION, PH_VERSION_LF, PH_HEADER, PH_HEADER_LF, PH_BODY
  } phase_t;

  typedef enum logic {CS_READY, CS_WALK} cstate_t;

  logic [15:0]      timeout;
  cstate_t          cs, cs_next;
  phase_t           phase, phase_next;
  logic [LEN_W-1:0] line_len, line_len_next;
  logic             hdr_end, hdr_end_next;
  logic [15:0]      body_cnt, body_cnt_next;
  logic [15:0]      length_val, length_val_next;
  logic [15:0]      idle_cnt, idle_cnt_next;
  logic             fin, fin_next;
  logic             vflag, vflag_next;

  logic             out_vld, out_vld_next;
  logic [2:0]       out_kind, out_kind_next;
  logic [7:0]       out_char, out_char_next;
  logic             out_done, out_done_next;
  logic             out_ok, out_ok_next;
  logic [15:0]      out_len, out_len_next;

  logic             s_fire;
  logic             load;
  logic [2:0]       kind;
  logic [7:0]       ch;
  logic [7:0]       c;
  logic [15:0]      idle_inc;

  line_wr_t         wr;
  chk_req_t         req;
  chk_res_t         res;

  hrbp_line_check u_check (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .req (req),
    .res (res)
  );

  assign c             = s_axis_tdata;
  assign s_axis_tready = (cs == CS_READY) && (!out_vld || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign idle_inc      = (idle_cnt != 16'hFFFF) ? idle_cnt + 16'd1 : idle_cnt;

  always_comb begin
    cs_next         = cs;
    phase_next      = phase;
    line_len_next   = line_len;
    hdr_end_next    = hdr_end;
    body_cnt_next   = body_cnt;
    length_val_next = length_val;
    idle_cnt_next   = idle_cnt;
    fin_next        = fin;
    vflag_next      = vflag;
    out_vld_next    = out_vld && !m_axis_tready;
    out_kind_next   = out_kind;
    out_char_next   = out_char;
    out_done_next   = out_done;
    out_ok_next     = out_ok;
    out_len_next    = out_len;
    wr.en           = 1'b0;
    wr.addr         = line_len[ADDR_W-1:0];
    wr.data         = c;
    req.start       = 1'b0;
    req.len         = line_len;
    load            = 1'b0;
    kind            = TK_NONE;
    ch              = 8'd0;

    if (cs == CS_READY && s_fire) begin
      load = 1'b1;
      unique case (s_axis_tuser)
        MODE_RESTART: begin
          phase_next      = PH_METHOD;
          line_len_next   = '0;
          hdr_end_next    = 1'b0;
          body_cnt_next   = '0;
          length_val_next = '0;
          idle_cnt_next   = '0;
          fin_next        = 1'b0;
          vflag_next      = 1'b1;
        end
        MODE_TICK: begin
          if (!fin) begin
            idle_cnt_next = idle_inc;
            if (idle_inc >= timeout) begin
              vflag_next = 1'b0;
              fin_next   = 1'b1;
            end
          end
        end
        MODE_BYTE: begin
          if (!fin) begin
            idle_cnt_next = '0;
            unique case (phase)
              PH_METHOD: begin
                if (c == CH_SP) begin
                  kind       = TK_METHOD_END;
                  phase_next = PH_PATH;
                end else begin
                  kind = TK_METHOD_CHAR;
                  ch   = c;
                end
              end
              PH_PATH: begin
                if (c == CH_SP) begin
                  kind       = TK_PATH_END;
                  phase_next = PH_VERSION;
                end else begin
                  kind = TK_PATH_CHAR;
                  ch   = c;
                end
              end
              PH_VERSION: begin
                if (c == CH_CR) begin
                  kind       = TK_VER_END;
                  phase_next = PH_VERSION_LF;
                end else begin
                  kind = TK_VER_CHAR;
                  ch   = c;
                end
              end
              PH_VERSION_LF: begin
                if (c == CH_LF) begin
                  line_len_next = '0;
                  phase_next    = PH_HEADER;
                end
              end
              PH_HEADER: begin
                if (c == CH_CR) begin
                  if (line_len == '0) begin
                    hdr_end_next = 1'b1;
                    phase_next   = PH_HEADER_LF;
                  end else begin
                    req.start = 1'b1;
                    load      = 1'b0;
                    cs_next   = CS_WALK;
                  end
                end else if (line_len < LEN_W'(LINE_MAX)) begin
                  wr.en         = 1'b1;
                  line_len_next = line_len + LEN_W'(1);
                end
              end
              PH_HEADER_LF: begin
                if (c == CH_LF) begin
                  if (hdr_end) begin
                    phase_next = PH_BODY;
                    if (length_val == 16'd0) begin
                      fin_next = 1'b1;
                    end
                  end else begin
                    phase_next = PH_HEADER;
                  end
                end
              end
              PH_BODY: begin
                if (body_cnt < length_val) begin
                  kind          = TK_BODY_CHAR;
                  ch            = c;
                  body_cnt_next = body_cnt + 16'd1;
                end
                if (body_cnt_next >= length_val) begin
                  fin_next = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end else if (cs == CS_WALK && res.done) begin
      load    = 1'b1;
      cs_next = CS_READY;
      if (res.type_bad) begin
        vflag_next = 1'b0;
        fin_next   = 1'b1;
      end else begin
        if (res.len_hit) begin
          length_val_next = res.len_val;
        end
        line_len_next = '0;
        phase_next    = PH_HEADER_LF;
      end
    end

    if (load) begin
      out_vld_next  = 1'b1;
      out_kind_next = kind;
      out_char_next = ch;
      out_done_next = fin_next;
      out_ok_next   = vflag_next;
      out_len_next  = length_val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= TIMEOUT_RESET;
      cs         <= CS_READY;
      phase      <= PH_METHOD;
      line_len   <= '0;
      hdr_end    <= 1'b0;
      body_cnt   <= '0;
      length_val <= '0;
      idle_cnt   <= '0;
      fin        <= 1'b0;
      vflag      <= 1'b1;
      out_vld    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      cs         <= cs_next;
      phase      <= phase_next;
      line_len   <= line_len_next;
      hdr_end    <= hdr_end_next;
      body_cnt   <= body_cnt_next;
      length_val <= length_val_next;
      idle_cnt   <= idle_cnt_next;
      fin        <= fin_next;
      vflag      <= vflag_next;
      out_vld    <= out_vld_next;
    end
    out_kind <= out_kind_next;
    out_char <= out_char_next;
    out_done <= out_done_next;
    out_ok   <= out_ok_next;
    out_len  <= out_len_next;
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'd0, out_len, out_ok, out_done, out_char};

endmodule

`default_nettype wire

// File: rtl/core/hrbp_line_check.sv
// ----------------------------------------------------------------------------
// hrbp_line_check: header line store and line check walker
// stores one header line and walks it a byte per cycle to check content type
// and parse content length
// ----------------------------------------------------------------------------
`default_nettype none

module hrbp_line_check import hrbp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire line_wr_t wr,
  input  wire chk_req_t req,
  output chk_res_t      res
);

  typedef enum logic {C_IDLE, C_WALK} cstate_t;
  typedef enum logic [1:0] {T_SKIP, T_MATCH, T_TAIL} tstate_t;
  typedef enum logic [1:0] {L_SKIP, L_DIG, L_STOP} lstate_t;

  logic [7:0]       mem [LINE_MAX];
  logic [7:0]       rdata;

  cstate_t          state;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] pidx;
  logic             pend;

  logic             tpre, tpre_next;
  tstate_t          tst, tst_next;
  logic [3:0]       tj, tj_next;
  logic             tbad, tbad_next;

  logic             lpre, lpre_next;
  lstate_t          lst, lst_next;
  logic             neg, neg_next;
  logic             any, any_next;
  logic [15:0]      val, val_next;
  logic [19:0]      acc;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[idx[ADDR_W-1:0]];
  end

  // per byte checks
  always_comb begin
    tpre_next = tpre;
    tst_next  = tst;
    tj_next   = tj;
    tbad_next = tbad;
    lpre_next = lpre;
    lst_next  = lst;
    neg_next  = neg;
    any_next  = any;
    val_next  = val;
    acc = 20'({val, 3'b000}) + 20'({val, 1'b0}) + 20'(rdata[3:0]);

    if (pidx < LEN_W'(TYPE_KEY_LEN)) begin
      tpre_next = tpre && (rdata == TYPE_KEY[pidx[3:0]]);
    end else begin
      unique case (tst)
        T_SKIP: begin
          if (!is_blank(rdata)) begin
            if (rdata == JSON_WORD[0]) begin
              tj_next  = 4'd1;
              tst_next = T_MATCH;
            end else begin
              tbad_next = 1'b1;
            end
          end
        end
        T_MATCH: begin
          if (rdata == JSON_WORD[tj]) begin
            if (tj == 4'd15) begin
              tst_next = T_TAIL;
            end else begin
              tj_next = tj + 4'd1;
            end
          end else begin
            tbad_next = 1'b1;
          end
        end
        T_TAIL: begin
          if (!is_blank(rdata)) begin
            tbad_next = 1'b1;
          end
        end
        default: tbad_next = 1'b1;
      endcase
    end

    if (pidx < LEN_W'(LEN_KEY_LEN)) begin
      lpre_next = lpre && (rdata == LEN_KEY[pidx[3:0]]);
    end else begin
      unique case (lst)
        L_SKIP: begin
          if (rdata == CH_PLUS || rdata == CH_MINUS) begin
            neg_next = (rdata == CH_MINUS);
            lst_next = L_DIG;
          end else if (is_digit(rdata)) begin
            val_next = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
            any_next = 1'b1;
            lst_next = L_DIG;
          end else if (!is_blank(rdata)) begin
            lst_next = L_STOP;
          end
        end
        L_DIG: begin
          if (is_digit(rdata)) begin
            val_next = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
            any_next = 1'b1;
          end else begin
            lst_next = L_STOP;
          end
        end
        L_STOP: ;
        default: lst_next = L_STOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      pend     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            len   <= req.len;
            idx   <= '0;
            pidx  <= '0;
            pend  <= 1'b0;
            tpre  <= 1'b1;
            tst   <= T_SKIP;
            tj    <= '0;
            tbad  <= 1'b0;
            lpre  <= 1'b1;
            lst   <= L_SKIP;
            neg   <= 1'b0;
            any   <= 1'b0;
            val   <= '0;
            state <= C_WALK;
          end
        end
        C_WALK: begin
          if (pend) begin
            tpre <= tpre_next;
            tst  <= tst_next;
            tj   <= tj_next;
            tbad <= tbad_next;
            lpre <= lpre_next;
            lst  <= lst_next;
            neg  <= neg_next;
            any  <= any_next;
            val  <= val_next;
          end
          if (idx < len) begin
            pidx <= idx;
            idx  <= idx + LEN_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (idx == len && !pend) begin
            res.done     <= 1'b1;
            res.type_bad <= tpre && (len >= LEN_W'(TYPE_KEY_LEN)) &&
                            (tbad || tst != T_TAIL);
            res.len_hit  <= lpre && (len >= LEN_W'(LEN_KEY_LEN));
            res.len_val  <= (any && !neg) ? val : 16'd0;
            state        <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
